### hw/rtl/lpae_pkg.sv
// Package for the loop playback address engine: field widths, command codes,
// loop mode codes, microcode word layout and the microcode program itself.
// Depends on nothing; the top level imports it.
package lpae_pkg;

	// Default values of the top level's parameters.
	localparam int FRAME_ADDR_BITS_DEF = 24;
	localparam int BAR_GRANULE_DEF     = 4;

	// Fixed field widths.
	localparam int CFG_BITS        = 24;
	localparam int CFG_INDEX_BITS  = 8;
	localparam int OPCODE_BITS     = 3;
	localparam int SEEK_BITS       = 16;
	localparam int SEEK_FRAC_BITS  = 8;
	localparam int LOOP_BITS       = 2;
	localparam int IN_DATA_BITS    = 16;
	localparam int IN_USER_BITS    = 8;
	localparam int OUT_FIELD_BITS  = 2 * CFG_BITS + 3 + LOOP_BITS;
	localparam int OUT_DATA_BITS   = ((OUT_FIELD_BITS + 7) / 8) * 8;
	localparam int OUT_PAD_BITS    = OUT_DATA_BITS - OUT_FIELD_BITS;

	// Configuration register indexes.
	localparam logic [CFG_INDEX_BITS-1:0] REG_TOTAL_FRAMES   = 8'd0;
	localparam logic [CFG_INDEX_BITS-1:0] REG_FRAMES_PER_BAR = 8'd1;

	// Command codes.
	localparam logic [OPCODE_BITS-1:0] OP_TICK   = 3'd0;
	localparam logic [OPCODE_BITS-1:0] OP_PAUSE  = 3'd1;
	localparam logic [OPCODE_BITS-1:0] OP_MUTE   = 3'd2;
	localparam logic [OPCODE_BITS-1:0] OP_SEEK   = 3'd3;
	localparam logic [OPCODE_BITS-1:0] OP_LOOP   = 3'd4;

	// Loop modes.
	localparam logic [LOOP_BITS-1:0] LOOP_OFF   = 2'd0;
	localparam logic [LOOP_BITS-1:0] LOOP_ARMED = 2'd1;
	localparam logic [LOOP_BITS-1:0] LOOP_ON    = 2'd2;

	// Datapath micro-operations.
	localparam int UOP_BITS = 5;
	localparam logic [UOP_BITS-1:0] UOP_NOP           = 5'd0;
	localparam logic [UOP_BITS-1:0] UOP_OUT           = 5'd1;
	localparam logic [UOP_BITS-1:0] UOP_REGION_END    = 5'd2;
	localparam logic [UOP_BITS-1:0] UOP_REGION_LEN    = 5'd3;
	localparam logic [UOP_BITS-1:0] UOP_DIV_LOAD_TICK = 5'd4;
	localparam logic [UOP_BITS-1:0] UOP_DIV_STEP      = 5'd5;
	localparam logic [UOP_BITS-1:0] UOP_TICK_ADDR     = 5'd6;
	localparam logic [UOP_BITS-1:0] UOP_TICK_POS      = 5'd7;
	localparam logic [UOP_BITS-1:0] UOP_TOG_PAUSE     = 5'd8;
	localparam logic [UOP_BITS-1:0] UOP_TOG_MUTE      = 5'd9;
	localparam logic [UOP_BITS-1:0] UOP_SEEK_MUL      = 5'd10;
	localparam logic [UOP_BITS-1:0] UOP_SEEK_APPLY    = 5'd11;
	localparam logic [UOP_BITS-1:0] UOP_DIV_LOAD_BAR  = 5'd12;
	localparam logic [UOP_BITS-1:0] UOP_GRID_SET      = 5'd15;
	localparam logic [UOP_BITS-1:0] UOP_LOOP_CLEAR    = 5'd16;

	// Sequencer conditions.
	localparam int COND_BITS = 3;
	localparam logic [COND_BITS-1:0] COND_NEXT      = 3'd0;
	localparam logic [COND_BITS-1:0] COND_JUMP      = 3'd1;
	localparam logic [COND_BITS-1:0] COND_END       = 3'd2;
	localparam logic [COND_BITS-1:0] COND_SKIP_TICK = 3'd3;
	localparam logic [COND_BITS-1:0] COND_SEEK_OFF  = 3'd4;
	localparam logic [COND_BITS-1:0] COND_FPB_ZERO  = 3'd5;
	localparam logic [COND_BITS-1:0] COND_LOOPING   = 3'd6;
	localparam logic [COND_BITS-1:0] COND_DIV_MORE  = 3'd7;

	// Program addresses.
	localparam int PC_BITS = 5;
	localparam logic [PC_BITS-1:0] PC_OUT        = 5'd0;
	localparam logic [PC_BITS-1:0] PC_TICK       = 5'd1;
	localparam logic [PC_BITS-1:0] PC_TICK_DIV   = 5'd5;
	localparam logic [PC_BITS-1:0] PC_PAUSE      = 5'd8;
	localparam logic [PC_BITS-1:0] PC_MUTE       = 5'd9;
	localparam logic [PC_BITS-1:0] PC_SEEK       = 5'd10;
	localparam logic [PC_BITS-1:0] PC_LOOP       = 5'd13;
	localparam logic [PC_BITS-1:0] PC_BAR_DIV    = 5'd16;
	localparam logic [PC_BITS-1:0] PC_LOOP_CLEAR = 5'd18;

	typedef struct packed {
		logic [UOP_BITS-1:0]  uop;
		logic [COND_BITS-1:0] cond;
		logic [PC_BITS-1:0]   target;
	} ctrl_t;

	// Entry point of each command's routine.
	function automatic logic [PC_BITS-1:0] entry_pc(input logic [OPCODE_BITS-1:0] op);
		logic [PC_BITS-1:0] pc;
		case (op)
			OP_TICK:  pc = PC_TICK;
			OP_PAUSE: pc = PC_PAUSE;
			OP_MUTE:  pc = PC_MUTE;
			OP_SEEK:  pc = PC_SEEK;
			OP_LOOP:  pc = PC_LOOP;
			default:  pc = PC_OUT;
		endcase
		return pc;
	endfunction

	// Microcode program, one control word per step.
	function automatic ctrl_t ucode_rom(input logic [PC_BITS-1:0] pc);
		ctrl_t cw;
		case (pc)
			5'd0:  cw = '{UOP_OUT,           COND_END,       PC_OUT};
			5'd1:  cw = '{UOP_NOP,           COND_SKIP_TICK, PC_OUT};
			5'd2:  cw = '{UOP_REGION_END,    COND_NEXT,      PC_OUT};
			5'd3:  cw = '{UOP_REGION_LEN,    COND_NEXT,      PC_OUT};
			5'd4:  cw = '{UOP_DIV_LOAD_TICK, COND_NEXT,      PC_OUT};
			5'd5:  cw = '{UOP_DIV_STEP,      COND_DIV_MORE,  PC_TICK_DIV};
			5'd6:  cw = '{UOP_TICK_ADDR,     COND_NEXT,      PC_OUT};
			5'd7:  cw = '{UOP_TICK_POS,      COND_JUMP,      PC_OUT};
			5'd8:  cw = '{UOP_TOG_PAUSE,     COND_JUMP,      PC_OUT};
			5'd9:  cw = '{UOP_TOG_MUTE,      COND_JUMP,      PC_OUT};
			5'd10: cw = '{UOP_NOP,           COND_SEEK_OFF,  PC_OUT};
			5'd11: cw = '{UOP_SEEK_MUL,      COND_NEXT,      PC_OUT};
			5'd12: cw = '{UOP_SEEK_APPLY,    COND_JUMP,      PC_OUT};
			5'd13: cw = '{UOP_NOP,           COND_FPB_ZERO,  PC_OUT};
			5'd14: cw = '{UOP_NOP,           COND_LOOPING,   PC_LOOP_CLEAR};
			5'd15: cw = '{UOP_DIV_LOAD_BAR,  COND_NEXT,      PC_OUT};
			5'd16: cw = '{UOP_DIV_STEP,      COND_DIV_MORE,  PC_BAR_DIV};
			5'd17: cw = '{UOP_GRID_SET,      COND_JUMP,      PC_OUT};
			5'd18: cw = '{UOP_LOOP_CLEAR,    COND_JUMP,      PC_OUT};
			default: cw = '{UOP_NOP,         COND_JUMP,      PC_OUT};
		endcase
		return cw;
	endfunction

endpackage

### hw/rtl/loop_playback_address_engine.sv
// Top level of the loop playback address engine: microcoded sequencer, its
// datapath with a shared restoring divider, and the stream and config ports.
// Depends on lpae_pkg for widths, codes and the microcode program.

// The engine takes one command word at a time and returns exactly one status
// word for it. A frame tick runs the shared restoring divider, one quotient
// bit per cycle, and that divider sets how fast ticks can follow each other. A
// loop toggle that sets a loop point runs the divider once, by the grid size
// times the bar length. A new command is accepted as soon as the previous
// one has reached the output register, even while that result still waits
// to be taken. Configuration writes go straight into the two registers and
// are always ready; they must only be issued while no command is in flight.
module loop_playback_address_engine
	import lpae_pkg::*;
#(
	parameter int FRAME_ADDR_BITS = FRAME_ADDR_BITS_DEF,
	parameter int BAR_GRANULE     = BAR_GRANULE_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,

	input  logic                      cfg_valid,
	output logic                      cfg_ready,
	input  logic [CFG_INDEX_BITS-1:0] cfg_index,
	input  logic [CFG_BITS-1:0]       cfg_data,

	input  logic                      s_tvalid,
	output logic                      s_tready,
	// s_tdata: seek_bars[15:0]
	input  logic [IN_DATA_BITS-1:0]   s_tdata,
	// s_tuser: opcode[2:0], zeros above
	input  logic [IN_USER_BITS-1:0]   s_tuser,

	output logic                      m_tvalid,
	input  logic                      m_tready,
	// m_tdata: frame_address[23:0], frame_active[24], mute_flag[25],
	// pause_flag[26], loop_mode[28:27], play_position[52:29], zeros above
	output logic [OUT_DATA_BITS-1:0]  m_tdata
);

	// The datapath is as wide as the larger of the address and config fields.
	localparam int AW        = FRAME_ADDR_BITS;
	localparam int W         = (AW > CFG_BITS) ? AW : CFG_BITS;
	localparam int CNT_BITS  = $clog2(W);
	localparam int PROD_BITS = SEEK_BITS + CFG_BITS;
	localparam int DELTA_BITS = PROD_BITS - SEEK_FRAC_BITS;
	// The divisor also holds the grid size times the bar length.
	localparam int GRAN_BITS = $clog2(BAR_GRANULE + 1);
	localparam int DVW       = ((W > CFG_BITS + GRAN_BITS) ? W : CFG_BITS + GRAN_BITS) + 1;

	// Sequencer state.
	logic                busy_q;
	logic [PC_BITS-1:0]  pc_q;
	ctrl_t               cw;
	logic [UOP_BITS-1:0] uop;
	logic                take;
	logic [PC_BITS-1:0]  pc_next;
	logic                out_free;
	logic                finish;
	logic                accept;

	// Configuration and architectural state.
	logic [CFG_BITS-1:0]  tf_q;
	logic [CFG_BITS-1:0]  fpb_q;
	logic [AW-1:0]        pos_q;
	logic                 pause_q;
	logic                 mute_q;
	logic [LOOP_BITS-1:0] lstate_q;
	logic [AW-1:0]        lbegin_q;
	logic [AW-1:0]        lfinish_q;

	// Work registers.
	logic [SEEK_BITS-1:0] raw_q;
	logic [W-1:0]         end_q;
	logic [W-1:0]         start_q;
	logic [W-1:0]         len_q;
	logic [W-1:0]         quo_q;
	logic [W-1:0]         rem_q;
	logic [DVW-1:0]       dvsr_q;
	logic [CNT_BITS-1:0]  cnt_q;
	logic [W-1:0]         addr_q;
	logic                 active_q;
	logic [PROD_BITS-1:0] prod_q;
	logic [CFG_BITS-1:0]  room_q;

	// Output register.
	logic                     m_tvalid_q;
	logic [OUT_DATA_BITS-1:0] m_tdata_q;

	// Datapath combinational terms.
	logic [W-1:0]          pos_w;
	logic [W-1:0]          tf_w;
	logic [W-1:0]          end_sel;
	logic                  use_loop;
	logic [W-1:0]          start_sel;
	logic [W:0]            trial;
	logic [W:0]            trial_diff;
	logic                  trial_ge;
	logic [SEEK_BITS-1:0]  mag;
	logic [DELTA_BITS-1:0] delta;
	logic [DELTA_BITS-1:0] pos_d;
	logic [AW-1:0]         grid_point;

	assign cfg_ready = 1'b1;
	assign s_tready  = !busy_q;
	assign accept    = s_tvalid && !busy_q;
	assign m_tvalid  = m_tvalid_q;
	assign m_tdata   = m_tdata_q;

	// Fetch the control word; an idle sequencer executes nothing.
	assign cw  = ucode_rom(pc_q);
	assign uop = busy_q ? cw.uop : UOP_NOP;

	assign out_free = !m_tvalid_q || m_tready;
	assign finish   = busy_q && (cw.cond == COND_END) && out_free;

	always_comb begin
		case (cw.cond)
			COND_NEXT:      take = 1'b0;
			COND_JUMP:      take = 1'b1;
			COND_SKIP_TICK: take = pause_q || (tf_q == '0);
			COND_SEEK_OFF:  take = (fpb_q == '0) || (raw_q == '0);
			COND_FPB_ZERO:  take = (fpb_q == '0);
			COND_LOOPING:   take = (lstate_q == LOOP_ON);
			COND_DIV_MORE:  take = (cnt_q != '0);
			default:        take = 1'b0;
		endcase
		pc_next = take ? cw.target : pc_q + PC_BITS'(1);
	end

	assign pos_w = W'(pos_q);
	assign tf_w  = W'(tf_q);

	// Loop region: the loop end is clamped to the buffer, and a loop whose end
	// is not above its start falls back to the whole buffer.
	assign end_sel   = (W'(lfinish_q) < tf_w) ? W'(lfinish_q) : tf_w;
	assign use_loop  = (lstate_q == LOOP_ON) && (end_q > W'(lbegin_q));
	assign start_sel = use_loop ? W'(lbegin_q) : '0;

	// One step of the restoring divider: quo_q shifts the dividend out at the
	// top and the quotient in at the bottom.
	assign trial      = {rem_q, quo_q[W-1]};
	assign trial_diff = trial - dvsr_q[W:0];
	assign trial_ge   = (DVW'(trial) >= dvsr_q);

	assign mag   = raw_q[SEEK_BITS-1] ? (~raw_q + SEEK_BITS'(1)) : raw_q;
	assign delta = prod_q[PROD_BITS-1:SEEK_FRAC_BITS];
	assign pos_d = DELTA_BITS'(pos_q);

	// Snapping the bar index down to the grid and scaling it back to frames is
	// the same as dropping the remainder of the position by one grid span.
	assign grid_point = AW'(pos_w - rem_q);

	// Control, configuration and architectural state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q     <= 1'b0;
			pc_q       <= PC_OUT;
			m_tvalid_q <= 1'b0;
			tf_q       <= '0;
			fpb_q      <= '0;
			pos_q      <= '0;
			pause_q    <= 1'b0;
			mute_q     <= 1'b0;
			lstate_q   <= LOOP_OFF;
			lbegin_q   <= '0;
			lfinish_q  <= '0;
		end else begin
			if (cfg_valid) begin
				case (cfg_index)
					REG_TOTAL_FRAMES:   tf_q  <= cfg_data;
					REG_FRAMES_PER_BAR: fpb_q <= cfg_data;
					default: ;
				endcase
			end

			if (accept) begin
				busy_q <= 1'b1;
				pc_q   <= entry_pc(s_tuser[OPCODE_BITS-1:0]);
			end else if (busy_q) begin
				if (cw.cond == COND_END) begin
					if (out_free) begin
						busy_q <= 1'b0;
						pc_q   <= PC_OUT;
					end
				end else begin
					pc_q <= pc_next;
				end
			end

			if (finish) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end

			case (uop)
				UOP_TICK_POS: begin
					pos_q <= AW'(addr_q + W'(1));
				end
				UOP_TOG_PAUSE: begin
					pause_q <= !pause_q;
				end
				UOP_TOG_MUTE: begin
					mute_q <= !mute_q;
				end
				UOP_SEEK_APPLY: begin
					// Forward seek is dropped unless it stays inside the buffer;
					// backward seek stops at frame zero.
					if (!raw_q[SEEK_BITS-1]) begin
						if (DELTA_BITS'(room_q) > delta) begin
							pos_q <= AW'(pos_d + delta);
						end
					end else if (pos_d > delta) begin
						pos_q <= AW'(pos_d - delta);
					end else begin
						pos_q <= '0;
					end
				end
				UOP_GRID_SET: begin
					if (lstate_q == LOOP_OFF) begin
						lbegin_q <= grid_point;
						lstate_q <= LOOP_ARMED;
					end else begin
						lfinish_q <= grid_point;
						lstate_q  <= LOOP_ON;
					end
				end
				UOP_LOOP_CLEAR: begin
					lstate_q <= LOOP_OFF;
				end
				default: ;
			endcase
		end
	end

	// Work registers and output payload.
	always_ff @(posedge clk) begin
		if (accept) begin
			raw_q    <= s_tdata[SEEK_BITS-1:0];
			addr_q   <= '0;
			active_q <= 1'b0;
		end

		if (finish) begin
			m_tdata_q <= {{OUT_PAD_BITS{1'b0}}, CFG_BITS'(pos_q), lstate_q, pause_q, mute_q,
				active_q, CFG_BITS'(addr_q)};
		end

		case (uop)
			UOP_REGION_END: begin
				end_q <= end_sel;
			end
			UOP_REGION_LEN: begin
				start_q <= start_sel;
				len_q   <= (use_loop ? end_q : tf_w) - start_sel;
			end
			UOP_DIV_LOAD_TICK: begin
				// A position below the loop start plays from the start.
				quo_q  <= (pos_w < start_q) ? '0 : pos_w - start_q;
				rem_q  <= '0;
				dvsr_q <= DVW'(len_q);
				cnt_q  <= CNT_BITS'(W - 1);
			end
			UOP_DIV_STEP: begin
				rem_q <= trial_ge ? trial_diff[W-1:0] : trial[W-1:0];
				quo_q <= {quo_q[W-2:0], trial_ge};
				cnt_q <= cnt_q - CNT_BITS'(1);
			end
			UOP_TICK_ADDR: begin
				addr_q   <= start_q + rem_q;
				active_q <= 1'b1;
			end
			UOP_SEEK_MUL: begin
				prod_q <= PROD_BITS'(mag) * PROD_BITS'(fpb_q);
				room_q <= (tf_w > pos_w) ? CFG_BITS'(tf_w - pos_w) : '0;
			end
			UOP_DIV_LOAD_BAR: begin
				// Divide the position by one grid span of bars.
				quo_q  <= pos_w;
				rem_q  <= '0;
				dvsr_q <= DVW'(fpb_q) * DVW'(BAR_GRANULE);
				cnt_q  <= CNT_BITS'(W - 1);
			end
			default: ;
		endcase
	end

endmodule
